FILE: hw/rtl/first_fit_block_allocator_core_macros.svh
// Assertion macros shared by the first-fit block allocator RTL.
// Included by the modules that carry concurrent assertions; needs no package.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FFBA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ffba assertion failed");

// Next-cycle implication, checked outside reset.
`define FFBA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ffba assertion failed");

`endif

FILE: hw/rtl/ffba_pkg.sv
// Package for the first-fit block allocator: default sizes, status and
// request codes, and the transfer structs. Depends on nothing.
`default_nettype none

package ffba_pkg;

  // Default sizing of the allocator.
  localparam int MAX_BLOCKS_DEF   = 16;
  localparam int HEAP_BYTES_DEF   = 65536;
  localparam int HEADER_BYTES_DEF = 16;

  // Heap limit register.
  localparam int              LIMIT_W     = 17;
  localparam logic [16:0]     LIMIT_RESET = 17'h10000;

  // Request types.
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_REUSED  = 3'd0;
  localparam logic [2:0] ST_NEW     = 3'd1;
  localparam logic [2:0] ST_BADSIZE = 3'd2;
  localparam logic [2:0] ST_OOM     = 3'd3;
  localparam logic [2:0] ST_FREED   = 3'd4;
  localparam logic [2:0] ST_IGNORED = 3'd5;

  // One request transfer.
  typedef struct packed {
    logic        req_type;
    logic [15:0] req_size;
    logic [15:0] free_addr;
  } ffba_req_t;

  // One result transfer.
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] payload_addr;
  } ffba_rsp_t;

  // Port enables of the block table.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ffba_mem_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ffba_table.sv
// Block table of the allocator: one synchronous memory, one write port and
// one registered read port. Depends on ffba_pkg for the port enable struct and the default depth.
`default_nettype none

module ffba_table #(
  parameter int  DEPTH = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int  WIDTH = 33,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire                  clk,
  input  ffba_pkg::ffba_mem_ctl_t ctl,
  input  wire  [AW-1:0]        rd_addr,
  output logic [WIDTH-1:0]     rd_data,
  input  wire  [AW-1:0]        wr_addr,
  input  wire  [WIDTH-1:0]     wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port: the data for rd_addr appears in the cycle after rd_en.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ffba_seq.sv
// Request sequencer of the allocator: scans the block table one entry per
// cycle, writes back the hit entry or appends a new one. Depends on ffba_pkg.
`default_nettype none
`include "first_fit_block_allocator_core_macros.svh"

module ffba_seq #(
  parameter int  MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int  HEAP_BYTES   = ffba_pkg::HEAP_BYTES_DEF,
  parameter int  HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
  localparam int IDX_W   = $clog2(MAX_BLOCKS),
  localparam int TOP_W   = $clog2(HEAP_BYTES + 1),
  localparam int ENTRY_W = 1 + 16 + TOP_W
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     start,
  output logic                    busy,
  input  ffba_pkg::ffba_req_t     req,
  input  wire  [TOP_W-1:0]        limit,
  output logic                    res_valid,
  output ffba_pkg::ffba_rsp_t     res,
  output ffba_pkg::ffba_mem_ctl_t mem_ctl,
  output logic [IDX_W-1:0]        rd_addr,
  input  wire  [ENTRY_W-1:0]      rd_data,
  output logic [IDX_W-1:0]        wr_addr,
  output logic [ENTRY_W-1:0]      wr_data
);

  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int NEED_W = $clog2(HEAP_BYTES + HEADER_BYTES + 65536);
  localparam int PA_W   = ($clog2(HEAP_BYTES + HEADER_BYTES + 1) > 16) ?
                          $clog2(HEAP_BYTES + HEADER_BYTES + 1) : 16;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_APPEND = 2'd2;

  typedef struct packed {
    logic             free;
    logic [15:0]      size;
    logic [TOP_W-1:0] start;
  } entry_t;

  logic [1:0]          state, state_next;
  ffba_pkg::ffba_req_t cur;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic [TOP_W-1:0]    top, top_next;
  logic [IDX_W-1:0]    chk_idx, chk_idx_next;
  logic [NEED_W-1:0]   need;

  logic             accept;
  entry_t           ent, wr_ent;
  logic [PA_W-1:0]  ent_pa, top_pa;
  logic [CNT_W-1:0] last_cnt;
  logic [IDX_W-1:0] last_idx;
  logic [CNT_W-1:0] chk_ext;
  logic             hit, is_last, cnt_full, no_room;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign ent    = entry_t'(rd_data);

  // Payload addresses of the entry under test and of the heap top.
  assign ent_pa = PA_W'(ent.start) + PA_W'(HEADER_BYTES);
  assign top_pa = PA_W'(top) + PA_W'(HEADER_BYTES);

  // Entry match for the request in flight.
  always_comb begin
    if (cur.req_type == ffba_pkg::REQ_ALLOC) begin
      hit = ent.free && (ent.size >= cur.req_size);
    end else begin
      hit = (ent_pa == PA_W'(cur.free_addr));
    end
  end

  assign last_cnt = cnt - CNT_W'(1);
  assign last_idx = last_cnt[IDX_W-1:0];
  assign is_last  = (chk_idx == last_idx);
  assign chk_ext  = CNT_W'(chk_idx);
  assign cnt_full = (cnt == CNT_W'(MAX_BLOCKS));
  assign no_room  = cnt_full || (need > NEED_W'(limit));

  // Sequencer: decides, scans, writes back and answers.
  always_comb begin
    state_next     = state;
    chk_idx_next   = chk_idx;
    cnt_next       = cnt;
    top_next       = top;
    mem_ctl.rd_en  = 1'b0;
    mem_ctl.wr_en  = 1'b0;
    rd_addr        = chk_idx + IDX_W'(1);
    wr_addr        = chk_idx;
    wr_ent         = ent;
    res_valid      = 1'b0;
    res.status     = ffba_pkg::ST_IGNORED;
    res.payload_addr = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          chk_idx_next = '0;
          rd_addr      = '0;
          priority if (req.req_type == ffba_pkg::REQ_ALLOC && req.req_size == '0) begin
            res_valid  = 1'b1;
            res.status = ffba_pkg::ST_BADSIZE;
          end else if (req.req_type == ffba_pkg::REQ_FREE && req.free_addr == '0) begin
            res_valid  = 1'b1;
            res.status = ffba_pkg::ST_IGNORED;
          end else if (cnt == '0) begin
            if (req.req_type == ffba_pkg::REQ_ALLOC) begin
              state_next = S_APPEND;
            end else begin
              res_valid  = 1'b1;
              res.status = ffba_pkg::ST_IGNORED;
            end
          end else begin
            mem_ctl.rd_en = 1'b1;
            state_next    = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        priority if (hit) begin
          mem_ctl.wr_en = 1'b1;
          res_valid     = 1'b1;
          state_next    = S_IDLE;
          if (cur.req_type == ffba_pkg::REQ_ALLOC) begin
            wr_ent.free      = 1'b0;
            res.status       = ffba_pkg::ST_REUSED;
            res.payload_addr = ent_pa[15:0];
          end else begin
            wr_ent.free = 1'b1;
            res.status  = ffba_pkg::ST_FREED;
          end
        end else if (is_last) begin
          if (cur.req_type == ffba_pkg::REQ_ALLOC) begin
            state_next = S_APPEND;
          end else begin
            res_valid  = 1'b1;
            res.status = ffba_pkg::ST_IGNORED;
            state_next = S_IDLE;
          end
        end else begin
          mem_ctl.rd_en = 1'b1;
          chk_idx_next  = chk_idx + IDX_W'(1);
        end
      end

      S_APPEND: begin
        res_valid  = 1'b1;
        state_next = S_IDLE;
        if (no_room) begin
          res.status = ffba_pkg::ST_OOM;
        end else begin
          mem_ctl.wr_en    = 1'b1;
          wr_addr          = cnt[IDX_W-1:0];
          wr_ent.free      = 1'b0;
          wr_ent.size      = cur.req_size;
          wr_ent.start     = top;
          res.status       = ffba_pkg::ST_NEW;
          res.payload_addr = top_pa[15:0];
          top_next         = need[TOP_W-1:0];
          cnt_next         = cnt + CNT_W'(1);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign wr_data = wr_ent;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      top     <= '0;
      chk_idx <= '0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      top     <= top_next;
      chk_idx <= chk_idx_next;
    end
  end

  // Request capture and the heap end an append would reach.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur  <= req;
      need <= NEED_W'(top) + NEED_W'(HEADER_BYTES) + NEED_W'(req.req_size);
    end
  end

  // Table writes happen only while a request is in flight.
  `FFBA_ASSERT_IMP(a_wr_in_flight, clk, rst, mem_ctl.wr_en, state != S_IDLE)
  // The scan never looks past the filled part of the table.
  `FFBA_ASSERT_IMP(a_scan_in_range, clk, rst, state == S_SCAN, chk_ext < cnt)
  // A new block grows the table by exactly one entry.
  `FFBA_ASSERT_NXT(a_new_grows, clk, rst, res_valid && res.status == ffba_pkg::ST_NEW, cnt == $past(cnt) + CNT_W'(1))
  // The block count stays within the table.
  `FFBA_ASSERT_IMP(a_cnt_bound, clk, rst, 1'b1, cnt <= CNT_W'(MAX_BLOCKS))

endmodule

`default_nettype wire

FILE: hw/rtl/first_fit_block_allocator_core.sv
// First-fit block allocator. A zero size, a null free or a free on an empty table is answered
// without a scan; otherwise the table is scanned from entry 0 up to the first hit, and a miss
// ends in an append or out of memory for an alloc and in an ignored free for a free. The scan
// reads one table entry per cycle from the single read port, then the hit, append or miss
// commits. A new start is taken in the done cycle.
// rst clears the block count, heap top and handshake state and sets heap_limit to 65536.
`default_nettype none

module first_fit_block_allocator_core #(
  parameter int  MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int  HEAP_BYTES   = ffba_pkg::HEAP_BYTES_DEF,
  parameter int  HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  output logic                        busy,
  input  ffba_pkg::ffba_req_t         req,
  output logic                        done,
  output ffba_pkg::ffba_rsp_t         result,
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire  [ffba_pkg::LIMIT_W-1:0] cfg_data
);

  localparam int IDX_W   = $clog2(MAX_BLOCKS);
  localparam int TOP_W   = $clog2(HEAP_BYTES + 1);
  localparam int ENTRY_W = 1 + 16 + TOP_W;

  logic [ffba_pkg::LIMIT_W-1:0] heap_limit;
  logic [TOP_W-1:0]             limit;
  logic                         res_valid;
  ffba_pkg::ffba_rsp_t          res;
  ffba_pkg::ffba_mem_ctl_t      mem_ctl;
  logic [IDX_W-1:0]             rd_addr, wr_addr;
  logic [ENTRY_W-1:0]           rd_data, wr_data;

  // Configuration transfers are taken whenever no request is in flight.
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_limit <= ffba_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      heap_limit <= cfg_data;
    end
  end

  // The limit in force is the smaller of the register and the heap size.
  always_comb begin
    if (32'(heap_limit) < 32'(HEAP_BYTES)) begin
      limit = TOP_W'(heap_limit);
    end else begin
      limit = TOP_W'(HEAP_BYTES);
    end
  end

  ffba_seq #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .limit     (limit),
    .res_valid (res_valid),
    .res       (res),
    .mem_ctl   (mem_ctl),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  ffba_table #(
    .DEPTH (MAX_BLOCKS),
    .WIDTH (ENTRY_W)
  ) u_table (
    .clk     (clk),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Result register: each result is shown for one cycle with done.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      result <= res;
    end
  end

endmodule

`default_nettype wire
